>>> rtl/round_robin_pick_with_cooldown_assert.svh
// Assertion macros shared by the RTL of the round-robin pick block.
`ifndef ROUND_ROBIN_PICK_WITH_COOLDOWN_ASSERT_SVH
`define ROUND_ROBIN_PICK_WITH_COOLDOWN_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RRPC_ASSERT_NOW(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RRPC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

>>> rtl/rrpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrpc_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_PICK = 2'd0;
  localparam logic [1:0] KIND_COOL = 2'd1;
  localparam logic [1:0] KIND_HEAL = 2'd2;

  // Width of one stored cooldown-until time.
  localparam int unsigned TIME_W = 49;

  // One request transaction.
  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] now_ms;
    logic [3:0]  entry_index;
    logic [31:0] cool_ms;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic       ok;
    logic [3:0] granted_index;
    logic [4:0] ready_count;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/round_robin_pick_with_cooldown.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+----------------------------------------
// request   | start, busy          | req (kind, now_ms, entry_index, cool_ms)
// result    | done (1-cycle strobe)| rsp (ok, granted_index, ready_count)
// config    | cfg_we               | cfg_data (entries_in_use)
//
// A request with a non-empty pool ends with a scan that reads one stored time per
// cycle from the cooldown RAM, over every entry of the pool. A pick first passes
// the fix-up state, which subtracts while the ring pointer must be brought back
// below a reduced pool size; an in-range update first passes the write state.
// An empty pool answers in the cycle after acceptance. busy is low in the
// done cycle, so the next request may be accepted then. Synchronous reset
// marks every entry available; there is no clearing pass. Results cannot stall.
module round_robin_pick_with_cooldown #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire rrpc_pkg::req_t req,
  output logic                done,
  output rrpc_pkg::rsp_t      rsp,
  input  wire logic           cfg_we,
  input  wire logic [4:0]     cfg_data
);

  localparam int unsigned DEPTH = (MAX_ENTRIES > 16) ? 16 : MAX_ENTRIES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [4:0]  DEPTH_N = 5'(DEPTH);

  logic [4:0]                  entries_in_use;
  logic [4:0]                  pool_size;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [rrpc_pkg::TIME_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [rrpc_pkg::TIME_W-1:0] ram_rdata;

  // Pool size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_we) begin
      entries_in_use <= cfg_data;
    end
  end

  // Pool size saturates at the RAM depth.
  assign pool_size = (entries_in_use > DEPTH_N) ? DEPTH_N : entries_in_use;

  rrpc_seq #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .pool_size (pool_size),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  rrpc_ram #(
    .WIDTH (rrpc_pkg::TIME_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`include "round_robin_pick_with_cooldown_assert.svh"

  // A transaction accepted with a non-empty pool makes the block busy next cycle.
  `RRPC_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy && (pool_size != 5'd0), busy)
  // The result strobe comes with the sequencer back in idle.
  `RRPC_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  // A refused pick or an update never reports a granted index.
  `RRPC_ASSERT_NOW(a_no_grant, clk, rst, done && !rsp.ok, rsp.granted_index == 4'd0)

endmodule

`default_nettype wire

>>> rtl/rrpc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module rrpc_ram #(
  parameter int unsigned WIDTH = 49,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rrpc_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Request sequencer: pointer fix-up, a write of the cooldown RAM
// and a one-entry-per-cycle scan that picks and counts.
module rrpc_seq #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire rrpc_pkg::req_t              req,
  input  wire logic [4:0]                  pool_size,
  output logic                             busy,
  output logic                             done,
  output rrpc_pkg::rsp_t                   rsp,
  output logic                             ram_we,
  output logic [AW-1:0]                    ram_waddr,
  output logic [rrpc_pkg::TIME_W-1:0]      ram_wdata,
  output logic                             ram_re,
  output logic [AW-1:0]                    ram_raddr,
  input  wire logic [rrpc_pkg::TIME_W-1:0] ram_rdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOD  = 3'd1;
  localparam logic [2:0] ST_WR   = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;

  logic [2:0]                  state;
  rrpc_pkg::req_t              req_q;
  logic [4:0]                  n_q;
  logic [3:0]                  ring_pointer;
  logic [4:0]                  start_q;
  logic [4:0]                  start_inc;
  logic [AW-1:0]               addr;
  logic [4:0]                  issue_cnt;
  logic                        rd_vld_q;
  logic [AW-1:0]               rd_addr_q;
  logic                        found;
  logic [3:0]                  grant_q;
  logic [4:0]                  count;
  logic                        upd_ok;
  logic [DEPTH-1:0]            valid;
  logic [rrpc_pkg::TIME_W-1:0] eff_time;
  logic                        is_avail;
  logic                        rd_issue;
  logic                        is_pick;

  assign busy      = (state != ST_IDLE);
  assign is_pick   = (req_q.kind == rrpc_pkg::KIND_PICK);
  assign start_inc = start_q + 5'd1;

  // RAM access: one read per scan cycle until all n_q reads are issued, one write in the update cycle.
  assign rd_issue  = (state == ST_SCAN) && (issue_cnt != n_q);
  assign ram_re    = rd_issue;
  assign ram_raddr = addr;
  assign ram_we    = (state == ST_WR);
  assign ram_waddr = req_q.entry_index[AW-1:0];
  assign ram_wdata = (req_q.kind == rrpc_pkg::KIND_COOL) ?
                     ({1'b0, req_q.now_ms} + {17'd0, req_q.cool_ms}) : '0;

  // An entry never written reads as expired at time zero.
  assign eff_time = valid[rd_addr_q] ? ram_rdata : '0;
  assign is_avail = (eff_time <= {1'b0, req_q.now_ms});

  // Sequencer.
  always_ff @(posedge clk) begin
    done     <= 1'b0;
    rd_vld_q <= 1'b0;
    if (rst) begin
      state        <= ST_IDLE;
      ring_pointer <= '0;
      valid        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            req_q     <= req;
            n_q       <= pool_size;
            start_q   <= {1'b0, ring_pointer};
            addr      <= '0;
            issue_cnt <= '0;
            found     <= 1'b0;
            grant_q   <= '0;
            count     <= '0;
            upd_ok    <= 1'b0;
            if (pool_size == 5'd0) begin
              // Empty pool answers at once.
              done  <= 1'b1;
              rsp   <= '0;
            end else begin
              unique case (req.kind) inside
                rrpc_pkg::KIND_PICK: state <= ST_MOD;
                rrpc_pkg::KIND_COOL, rrpc_pkg::KIND_HEAL: begin
                  if ({1'b0, req.entry_index} < pool_size) begin
                    upd_ok <= 1'b1;
                    state  <= ST_WR;
                  end else begin
                    state <= ST_SCAN;
                  end
                end
                default: state <= ST_SCAN;
              endcase
            end
          end
        end
        ST_MOD: begin
          // Reduce the pointer below the pool size by repeated subtraction.
          if (start_q >= n_q) begin
            start_q <= start_q - n_q;
          end else begin
            ring_pointer <= (start_inc == n_q) ? 4'd0 : start_inc[3:0];
            addr         <= start_q[AW-1:0];
            state        <= ST_SCAN;
          end
        end
        ST_WR: begin
          valid[req_q.entry_index[AW-1:0]] <= 1'b1;
          state                             <= ST_SCAN;
        end
        ST_SCAN: begin
          if (rd_issue) begin
            issue_cnt <= issue_cnt + 5'd1;
            addr      <= ((5'(addr) + 5'd1) == n_q) ? '0 : addr + AW'(1);
          end
          rd_vld_q  <= rd_issue;
          rd_addr_q <= addr;
          if (rd_vld_q && is_avail) begin
            count <= count + 5'd1;
            if (is_pick && !found) begin
              found   <= 1'b1;
              grant_q <= 4'(rd_addr_q);
            end
          end
          // All reads issued and the last one evaluated.
          if (!rd_issue && !rd_vld_q) begin
            done              <= 1'b1;
            rsp.ok            <= is_pick ? found : upd_ok;
            rsp.granted_index <= found ? grant_q : 4'd0;
            rsp.ready_count   <= count;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
